[design/dbp_pkg.sv]
// Shared types, widths and constants of the depth pixel back-projection block.
package dbp_pkg;

  localparam int DEPTH_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int RGB_W    = 3 * COLOR_W;
  localparam int COORD_W  = 32;
  localparam int PNUM_W   = 22;
  localparam int INV_W    = 24;
  localparam int CENTER_W = 19;
  localparam int SIZE_W   = 12;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 24;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Register indexes of the configuration port.
  localparam logic [CFG_AW-1:0] CFG_INV_FOCAL_X  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_INV_FOCAL_Y  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_CENTER_X     = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_CENTER_Y     = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 3'd5;

  // Controller to datapath.
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic mul1;     // offset times reciprocal focal length
    logic mul2;     // partial products with depth
    logic finish;   // round, saturate, load output register
  } dbp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic depth_nz; // pending input beat has a depth measurement
    logic out_free; // output register can take a point this cycle
  } dbp_sts_t;

endpackage

[design/dbp_ifs.sv]
// Handshake channels: pixel input, point output and configuration writes.
interface dbp_pix_if import dbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth_mm;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  modport source (output valid, output depth_mm, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input depth_mm, input red, input green, input blue,
                  output ready);
endinterface

interface dbp_pt_if import dbp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_mm_q8;
  logic signed [COORD_W-1:0] y_mm_q8;
  logic        [DEPTH_W-1:0] z_mm;
  logic        [RGB_W-1:0]   packed_rgb;
  logic        [PNUM_W-1:0]  point_number;
  modport source (output valid, output x_mm_q8, output y_mm_q8, output z_mm,
                  output packed_rgb, output point_number, input ready);
  modport sink   (input valid, input x_mm_q8, input y_mm_q8, input z_mm,
                  input packed_rgb, input point_number, output ready);
endinterface

interface dbp_cfg_if import dbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

[design/dbp_ctrl.sv]
// Sequencing state machine of the back-projection datapath.
module dbp_ctrl import dbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dbp_sts_t sts,
  output dbp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.mul1   = (state_r == ST_MUL1);
  assign cmd.mul2   = (state_r == ST_MUL2);
  assign cmd.finish = (state_r == ST_SUM) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        // zero-depth pixels only move the counters
        if (cmd.accept && sts.depth_nz) state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SUM;
      ST_SUM: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/dbp_datapath.sv]
// Config registers, raster counters, projection arithmetic and output register.
module dbp_datapath import dbp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dbp_cmd_t                  cmd,
  output dbp_sts_t                  sts,
  // configuration writes
  input  logic                      cfg_we,
  input  logic [CFG_AW-1:0]         cfg_addr,
  input  logic [CFG_DW-1:0]         cfg_wdata,
  // input payload
  input  logic [DEPTH_W-1:0]        depth_mm,
  input  logic [COLOR_W-1:0]        red,
  input  logic [COLOR_W-1:0]        green,
  input  logic [COLOR_W-1:0]        blue,
  // output beat
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] x_mm_q8,
  output logic signed [COORD_W-1:0] y_mm_q8,
  output logic        [DEPTH_W-1:0] z_mm,
  output logic        [RGB_W-1:0]   packed_rgb,
  output logic        [PNUM_W-1:0]  point_number
);

  localparam int P1_W   = CENTER_W + INV_W;      // offset * reciprocal
  localparam int LO_W   = 22;                    // low slice of P1 per partial product
  localparam int HI_W   = P1_W - LO_W;
  localparam int PL_W   = LO_W + DEPTH_W;
  localparam int PH_W   = HI_W + DEPTH_W;
  localparam int PROD_W = P1_W + DEPTH_W + 1;
  localparam int FRAC   = 24;
  localparam int R_W    = PROD_W - FRAC;

  // ---- configuration registers
  logic [INV_W-1:0]    inv_fx_r, inv_fy_r;
  logic [CENTER_W-1:0] center_x_r, center_y_r;
  logic [SIZE_W-1:0]   width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_fx_r   <= INV_W'(28796);
      inv_fy_r   <= INV_W'(28793);
      center_x_r <= CENTER_W'(80140);
      center_y_r <= CENTER_W'(61042);
      width_r    <= SIZE_W'(640);
      height_r   <= SIZE_W'(480);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_INV_FOCAL_X:  inv_fx_r   <= cfg_wdata[INV_W-1:0];
        CFG_INV_FOCAL_Y:  inv_fy_r   <= cfg_wdata[INV_W-1:0];
        CFG_CENTER_X:     center_x_r <= cfg_wdata[CENTER_W-1:0];
        CFG_CENTER_Y:     center_y_r <= cfg_wdata[CENTER_W-1:0];
        CFG_IMAGE_WIDTH:  width_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: height_r   <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- raster counters
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PNUM_W-1:0] pcnt_r, pcnt_nxt;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic              col_last, row_last;

  always_comb begin
    // zero acts as one, oversize acts as the maximum
    if (width_r == '0)                      w_eff = SIZE_W'(1);
    else if (width_r > SIZE_W'(MAX_WIDTH))  w_eff = SIZE_W'(MAX_WIDTH);
    else                                    w_eff = width_r;
    if (height_r == '0)                     h_eff = SIZE_W'(1);
    else if (height_r > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
    else                                    h_eff = height_r;
  end

  assign col_last = (SIZE_W'(col_r) + SIZE_W'(1)) >= w_eff;
  assign row_last = (SIZE_W'(row_r) + SIZE_W'(1)) >= h_eff;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    pcnt_nxt = pcnt_r;
    if (cmd.accept) begin
      if (depth_mm != '0) pcnt_nxt = pcnt_r + PNUM_W'(1);
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt  = '0;
          pcnt_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pcnt_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

  // ---- offsets from the principal point (lane 0 = x, lane 1 = y)
  logic [CENTER_W-1:0] pos_q8  [2];
  logic [CENTER_W-1:0] ctr     [2];
  logic [INV_W-1:0]    inv     [2];
  logic                neg_cur [2];
  logic [CENTER_W-1:0] mag_cur [2];

  assign pos_q8[0] = {col_r, 8'd0};
  assign pos_q8[1] = {row_r, 8'd0};
  assign ctr[0]    = center_x_r;
  assign ctr[1]    = center_y_r;
  assign inv[0]    = inv_fx_r;
  assign inv[1]    = inv_fy_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      neg_cur[i] = ctr[i] > pos_q8[i];
      mag_cur[i] = neg_cur[i] ? (ctr[i] - pos_q8[i]) : (pos_q8[i] - ctr[i]);
    end
  end

  // ---- per-point working registers
  logic [DEPTH_W-1:0]  depth_r;
  logic [RGB_W-1:0]    rgb_r;
  logic [PNUM_W-1:0]   pnum_r;
  logic                neg_r [2];
  logic [CENTER_W-1:0] mag_r [2];
  logic [P1_W-1:0]     p1_r  [2];
  logic [PL_W-1:0]     pl_r  [2];
  logic [PH_W-1:0]     ph_r  [2];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      depth_r <= depth_mm;
      rgb_r   <= {red, green, blue};
      pnum_r  <= pcnt_r;
      for (int i = 0; i < 2; i++) begin
        neg_r[i] <= neg_cur[i];
        mag_r[i] <= mag_cur[i];
      end
    end
    if (cmd.mul1) begin
      for (int i = 0; i < 2; i++) begin
        p1_r[i] <= P1_W'(mag_r[i]) * P1_W'(inv[i]);
      end
    end
    if (cmd.mul2) begin
      // 43 x 16 split into two narrower products
      for (int i = 0; i < 2; i++) begin
        pl_r[i] <= PL_W'(p1_r[i][LO_W-1:0]) * PL_W'(depth_r);
        ph_r[i] <= PH_W'(p1_r[i][P1_W-1:LO_W]) * PH_W'(depth_r);
      end
    end
  end

  // ---- round half away from zero on the magnitude, then saturate
  logic [PROD_W-1:0]         prod [2];
  logic [R_W-1:0]            rnd  [2];
  logic [COORD_W-1:0]        lim  [2];
  logic signed [COORD_W-1:0] res  [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod[i] = PROD_W'(pl_r[i]) + (PROD_W'(ph_r[i]) << LO_W)
              + (PROD_W'(1) << (FRAC - 1));
      rnd[i]  = prod[i][PROD_W-1:FRAC];
      if (neg_r[i]) begin
        lim[i] = (rnd[i] > R_W'(33'h0_8000_0000)) ? 32'h8000_0000 : rnd[i][COORD_W-1:0];
        res[i] = signed'(COORD_W'(0) - lim[i]);
      end else begin
        lim[i] = (rnd[i] > R_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : rnd[i][COORD_W-1:0];
        res[i] = signed'(lim[i]);
      end
    end
  end

  // ---- output register
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic        [DEPTH_W-1:0] z_r;
  logic        [RGB_W-1:0]   rgb_out_r;
  logic        [PNUM_W-1:0]  pnum_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      x_r        <= res[0];
      y_r        <= res[1];
      z_r        <= depth_r;
      rgb_out_r  <= rgb_r;
      pnum_out_r <= pnum_r;
    end
  end

  assign sts.depth_nz = (depth_mm != '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign x_mm_q8      = x_r;
  assign y_mm_q8      = y_r;
  assign z_mm         = z_r;
  assign packed_rgb   = rgb_out_r;
  assign point_number = pnum_out_r;

endmodule

[design/depth_pixel_backprojection.sv]
// Top level: pinhole back-projection of a depth/color raster into colored 3D points.
//
// Pixels arrive in row-major order, one per input beat, with a depth in mm and
// an RGB color; internal column/row counters wrap at image_width/image_height
// (zero acts as one, sizes above 2048 act as 2048). A pixel with zero depth is
// consumed and produces no point. Any other pixel passes from input beat to
// output register through offset capture, offset times reciprocal focal
// length, two partial products with the depth, then round and saturate.
// The next pixel is taken in the cycle after the point is loaded, so no new
// pixel is taken while a valid depth is in the multiply sequence; a stalled
// output holds the sequence in its last step. The output register lets a new
// pixel start while the previous point waits to be taken.
// x_mm_q8/y_mm_q8 carry 8 fractional bits, rounded half away from zero and
// saturated to 32 bits; point_number restarts at zero with each frame.
// Configuration writes are always ready and must only happen while idle.
module depth_pixel_backprojection import dbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dbp_pix_if.sink   in_chan,
  dbp_pt_if.source  out_chan,
  dbp_cfg_if.sink   cfg_chan
);

  dbp_cmd_t cmd;
  dbp_sts_t sts;

  // register writes are never stalled
  assign cfg_chan.ready = 1'b1;

  dbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dbp_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_chan.valid && cfg_chan.ready),
    .cfg_addr     (cfg_chan.addr),
    .cfg_wdata    (cfg_chan.wdata),
    .depth_mm     (in_chan.depth_mm),
    .red          (in_chan.red),
    .green        (in_chan.green),
    .blue         (in_chan.blue),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .x_mm_q8      (out_chan.x_mm_q8),
    .y_mm_q8      (out_chan.y_mm_q8),
    .z_mm         (out_chan.z_mm),
    .packed_rgb   (out_chan.packed_rgb),
    .point_number (out_chan.point_number)
  );

endmodule
